FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/pwpc_pkg.sv
// constants and widths for the pulse width to per-mille channel
// no dependencies; used by the interfaces, the core and the checker
package pwpc_pkg;

	localparam int W_PULSE = 16;
	localparam int W_DB    = 10;
	localparam int W_CMD   = 11;
	localparam int W_IDX   = 3;
	localparam int W_DATA  = 16;

	// quotient bits resolved by the divider, saturation handles the rest
	localparam int QUOT_BITS = 10;
	// 1000 * 65535 fits in 26 bits
	localparam int W_PROD = 26;
	localparam int W_DVD  = W_PROD + QUOT_BITS;

	// decode, multiply, band subtract, scale, saturation check, divider, output
	localparam int NUM_STAGES = 4 + 1 + QUOT_BITS + 1;

	localparam logic [W_CMD-1:0] FULL_SCALE = W_CMD'(1000);

	localparam logic [W_IDX-1:0] REG_LOW_WIDTH = W_IDX'(0);
	localparam logic [W_IDX-1:0] REG_HIGH_WIDTH = W_IDX'(1);
	localparam logic [W_IDX-1:0] REG_DEAD_BAND = W_IDX'(2);
	localparam logic [W_IDX-1:0] REG_REVERSE = W_IDX'(3);
	localparam logic [W_IDX-1:0] REG_POS_ONLY = W_IDX'(4);

	localparam logic [W_PULSE-1:0] RST_LOW_WIDTH = W_PULSE'(1000);
	localparam logic [W_PULSE-1:0] RST_HIGH_WIDTH = W_PULSE'(2000);

endpackage

FILE: rtl/core/pwpc_if.sv
// valid/ready channel interfaces: measurement in, command out, register writes
// depends on pwpc_pkg for field widths
interface pwpc_meas_if;
	logic                            valid;
	logic                            ready;
	logic [pwpc_pkg::W_PULSE-1:0]    pulse_width_us;

	modport source (output valid, output pulse_width_us, input ready);
	modport sink (input valid, input pulse_width_us, output ready);
endinterface

interface pwpc_cmd_if;
	logic                            valid;
	logic                            ready;
	logic signed [pwpc_pkg::W_CMD-1:0] command_permille;
	logic                            config_error;

	modport source (output valid, output command_permille, output config_error, input ready);
	modport sink (input valid, input command_permille, input config_error, output ready);
endinterface

interface pwpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pwpc_pkg::W_IDX-1:0]      reg_index;
	logic [pwpc_pkg::W_DATA-1:0]     wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/core/pulse_width_to_permille_channel.sv
// Converts a measured RC pulse width into a per-mille command, bipolar
// (-1000..1000) or positive-only (0..1000), with dead band removal and
// reversal. One measurement is accepted every clock cycle unless a stall at the
// output reaches the input; results wait in the output register until taken.
// Results pass through the 16-stage pipeline: decode, three multiply and
// subtract stages, a saturation check and a 10-stage restoring divider that
// resolves one quotient bit per stage, then the output register. A stall at
// the output only stops stages that hold data, so empty stages keep filling.
// Degenerate limits or dead band give a command of 0 with config_error set.
// Registers are written through the cfg channel, which is always ready;
// write them only while no measurement is in flight.
module pulse_width_to_permille_channel (
	input  logic         clk,
	input  logic         arst_n,
	pwpc_meas_if.sink    meas,
	pwpc_cmd_if.source   cmd,
	pwpc_cfg_if.sink     cfg
);

	localparam int NS = pwpc_pkg::NUM_STAGES;
	localparam int QB = pwpc_pkg::QUOT_BITS;
	localparam int WP = pwpc_pkg::W_PULSE;
	localparam int WR = pwpc_pkg::W_PROD;
	localparam int WD = pwpc_pkg::W_DVD;
	localparam int WC = pwpc_pkg::W_CMD;

	typedef struct packed {
		logic flip;
		logic err;
	} ctl_t;

	// configuration registers
	logic [WP-1:0]               low_width_q;
	logic [WP-1:0]               high_width_q;
	logic [pwpc_pkg::W_DB-1:0]   dead_band_q;
	logic                        reverse_q;
	logic                        pos_only_q;

	logic [NS:1]   stage_vld_q;
	logic [NS:1]   vld_in;
	logic [NS+1:1] adv;

	logic [WP-1:0] num_s1;
	logic [WP-1:0] den_s1;
	ctl_t          ctl_s1;

	logic [WR-1:0] scaled_s2;
	logic [WR-1:0] band_s2;
	logic [WR-1:0] dvs_s2;
	ctl_t          ctl_s2;

	logic [WR-1:0] diff_s3;
	logic [WR-1:0] dvs_s3;
	ctl_t          ctl_s3;

	logic [WD-1:0] dvd_s4;
	logic [WR-1:0] dvs_s4;
	ctl_t          ctl_s4;

	// element k of the divider arrays is pipeline stage 5+k
	logic [WD-1:0] div_rem_s [0:QB-1];
	logic [WR-1:0] div_dvs_s [0:QB-1];
	logic          div_sat_s [0:QB];
	ctl_t          div_ctl_s [0:QB];
	logic [QB-1:0] div_quo_s [1:QB];

	logic signed [WC-1:0] cmd_d;
	logic signed [WC-1:0] cmd_s16;
	logic                 err_s16;

	// stage 1 decode results
	logic [WP-1:0] num_d;
	logic [WP-1:0] den_d;
	ctl_t          ctl_d;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_width_q  <= pwpc_pkg::RST_LOW_WIDTH;
			high_width_q <= pwpc_pkg::RST_HIGH_WIDTH;
			dead_band_q  <= '0;
			reverse_q    <= 1'b0;
			pos_only_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				pwpc_pkg::REG_LOW_WIDTH:  low_width_q  <= cfg.wdata;
				pwpc_pkg::REG_HIGH_WIDTH: high_width_q <= cfg.wdata;
				pwpc_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg.wdata[pwpc_pkg::W_DB-1:0];
				pwpc_pkg::REG_REVERSE:    reverse_q    <= cfg.wdata[0];
				pwpc_pkg::REG_POS_ONLY:   pos_only_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	// a stage advances when it is empty or the stage after it advances
	assign adv[NS+1] = cmd.ready;
	genvar g;
	generate
		for (g = 1; g <= NS; g++) begin : g_adv
			assign adv[g] = !stage_vld_q[g] || adv[g+1];
			if (g == 1) begin : g_first
				assign vld_in[g] = meas.valid;
			end else begin : g_rest
				assign vld_in[g] = stage_vld_q[g-1];
			end
		end
	endgenerate

	assign meas.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) begin
					stage_vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// ---------------- stage 1: position as num/den ----------------
	always_comb begin
		logic [WP-1:0] span;
		logic [WP-1:0] mid;
		logic [WP-1:0] w;
		logic [WP-1:0] num_b;
		logic [WP-1:0] den_b;
		logic          neg;
		logic          bad_cfg;
		w       = meas.pulse_width_us;
		span    = high_width_q - low_width_q;
		mid     = (span >> 1) + low_width_q;
		bad_cfg = (high_width_q <= low_width_q) ||
			({1'b0, dead_band_q} >= pwpc_pkg::FULL_SCALE);
		if (w >= mid) begin
			num_b = w - mid;
			den_b = high_width_q - mid;
			neg   = 1'b0;
		end else begin
			num_b = mid - w;
			den_b = mid - low_width_q;
			neg   = 1'b1;
		end
		if (num_b > den_b) begin
			num_b = den_b;
		end
		if (pos_only_q) begin
			den_d = span;
			if (reverse_q) begin
				num_d = (high_width_q > w) ? high_width_q - w : '0;
			end else begin
				num_d = (w > low_width_q) ? w - low_width_q : '0;
			end
			ctl_d.flip = 1'b0;
			ctl_d.err  = bad_cfg;
		end else begin
			den_d = den_b;
			num_d = num_b;
			ctl_d.flip = neg ^ reverse_q;
			// empty lower half gives a zero denominator
			ctl_d.err  = bad_cfg || (den_b == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && vld_in[1]) begin
			num_s1 <= num_d;
			den_s1 <= den_d;
			ctl_s1 <= ctl_d;
		end
	end

	// ---------------- stage 2: products ----------------
	always_ff @(posedge clk) begin
		if (adv[2] && vld_in[2]) begin
			scaled_s2 <= WR'(num_s1) * WR'(pwpc_pkg::FULL_SCALE);
			band_s2   <= WR'(dead_band_q) * WR'(den_s1);
			dvs_s2    <= WR'(pwpc_pkg::FULL_SCALE - {1'b0, dead_band_q}) * WR'(den_s1);
			ctl_s2    <= ctl_s1;
		end
	end

	// ---------------- stage 3: remove dead band ----------------
	always_ff @(posedge clk) begin
		if (adv[3] && vld_in[3]) begin
			diff_s3 <= (scaled_s2 >= band_s2) ? scaled_s2 - band_s2 : '0;
			dvs_s3  <= dvs_s2;
			ctl_s3  <= ctl_s2;
		end
	end

	// ---------------- stage 4: rescale to per-mille ----------------
	always_ff @(posedge clk) begin
		if (adv[4] && vld_in[4]) begin
			dvd_s4 <= WD'(diff_s3) * WD'(pwpc_pkg::FULL_SCALE);
			dvs_s4 <= dvs_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// ---------------- stage 5: saturation check ----------------
	// quotients of 1024 and up saturate, the divider resolves the rest
	always_ff @(posedge clk) begin
		if (adv[5] && vld_in[5]) begin
			div_rem_s[0] <= dvd_s4;
			div_dvs_s[0] <= dvs_s4;
			div_sat_s[0] <= {1'b0, dvd_s4} >= {1'b0, dvs_s4, {QB{1'b0}}};
			div_ctl_s[0] <= ctl_s4;
		end
	end

	// ---------------- stages 6..15: restoring divider ----------------
	generate
		for (g = 1; g <= QB; g++) begin : g_div
			logic [WD:0]   trial;
			logic [QB-1:0] quo_prev;
			assign trial = {1'b0, div_rem_s[g-1]} -
				({1'b0, WD'(div_dvs_s[g-1])} << (QB - g));
			if (g == 1) begin : g_q0
				assign quo_prev = '0;
			end else begin : g_qn
				assign quo_prev = div_quo_s[g-1];
			end

			always_ff @(posedge clk) begin
				if (adv[5+g] && vld_in[5+g]) begin
					div_quo_s[g] <= {quo_prev[QB-2:0], !trial[WD]};
					div_sat_s[g] <= div_sat_s[g-1];
					div_ctl_s[g] <= div_ctl_s[g-1];
				end
			end

			// the last stage needs no remainder or divisor
			if (g < QB) begin : g_carry
				always_ff @(posedge clk) begin
					if (adv[5+g] && vld_in[5+g]) begin
						div_rem_s[g] <= trial[WD] ? div_rem_s[g-1] : trial[WD-1:0];
						div_dvs_s[g] <= div_dvs_s[g-1];
					end
				end
			end
		end
	endgenerate

	// ---------------- stage 16: limit, sign, error ----------------
	always_comb begin
		logic [WC-1:0] mag;
		logic [WC-1:0] quo_ext;
		quo_ext = WC'(div_quo_s[QB]);
		if (div_sat_s[QB] || quo_ext > pwpc_pkg::FULL_SCALE) begin
			mag = pwpc_pkg::FULL_SCALE;
		end else begin
			mag = quo_ext;
		end
		cmd_d = div_ctl_s[QB].flip ? -$signed(mag) : $signed(mag);
		if (div_ctl_s[QB].err) begin
			cmd_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS] && vld_in[NS]) begin
			cmd_s16 <= cmd_d;
			err_s16 <= div_ctl_s[QB].err;
		end
	end

	assign cmd.valid            = stage_vld_q[NS];
	assign cmd.command_permille = cmd_s16;
	assign cmd.config_error     = err_s16;

endmodule

FILE: rtl/core/pwpc_checker.sv
// port-level checks on the pulse width to per-mille channel output
// depends on pwpc_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module pwpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cmd_valid,
	input logic                             cmd_ready,
	input logic signed [pwpc_pkg::W_CMD-1:0] cmd_value,
	input logic                             cmd_err
);

	localparam logic signed [pwpc_pkg::W_CMD-1:0] POS_LIMIT =
		$signed(pwpc_pkg::FULL_SCALE);
	localparam logic signed [pwpc_pkg::W_CMD-1:0] NEG_LIMIT =
		-$signed(pwpc_pkg::FULL_SCALE);

	// a stalled result stays offered
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, cmd_valid && !cmd_ready, cmd_valid)

	// a stalled result keeps its payload
	`ASSERT_NEXT(a_hold_data, clk, arst_n, cmd_valid && !cmd_ready,
		$stable(cmd_value) && $stable(cmd_err))

	// a degenerate configuration forces the command to zero
	`ASSERT_SAME(a_err_zero, clk, arst_n, cmd_valid && cmd_err, cmd_value == '0)

	// command never leaves full scale
	`ASSERT_SAME(a_range, clk, arst_n, cmd_valid,
		(cmd_value <= POS_LIMIT) && (cmd_value >= NEG_LIMIT))

endmodule

bind pulse_width_to_permille_channel pwpc_checker u_pwpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_value (cmd.command_permille),
	.cmd_err   (cmd.config_error)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for pulse_width_to_permille_channel: drives measurements
// and register writes, predicts each command, checks it; needs pwpc_pkg and pwpc_if
module tb_top;
	import pwpc_pkg::*;

	localparam int LIMIT = 400000;
	localparam int LONG_HOLD = 80;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_ITEMS = 88;

	typedef struct {
		logic [W_PULSE-1:0]      width;
		logic signed [W_CMD-1:0] cmd;
		logic                    err;
	} command_t;

	class command_checker;
		logic [W_PULSE-1:0] low_us;
		logic [W_PULSE-1:0] high_us;
		logic [W_DB-1:0]    band;
		logic               rev;
		logic               pos_only;
		command_t           expected_cmds[$];
		int                 errors;

		function new();
			low_us = RST_LOW_WIDTH;
			high_us = RST_HIGH_WIDTH;
			band = '0;
			rev = 1'b0;
			pos_only = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [W_IDX-1:0] idx, logic [W_DATA-1:0] data);
			case (idx)
				REG_LOW_WIDTH: low_us = data;
				REG_HIGH_WIDTH: high_us = data;
				REG_DEAD_BAND: band = data[W_DB-1:0];
				REG_REVERSE: rev = data[0];
				REG_POS_ONLY: pos_only = data[0];
				default: ;
			endcase
		endfunction

		// remove the dead band from position num/den and rescale to per-mille
		function longint unsigned strip_band(longint unsigned num, longint unsigned den,
				longint unsigned d);
			longint unsigned scaled, cut;
			scaled = 1000 * num;
			cut = d * den;
			if (scaled < cut)
				return 0;
			return ((scaled - cut) * 1000) / ((1000 - d) * den);
		endfunction

		function command_t calc_command(logic [W_PULSE-1:0] w);
			longint unsigned lo, hi, d, pw, mid, num, den, mag;
			longint c;
			logic neg;
			command_t r;
			lo = low_us;
			hi = high_us;
			d = band;
			pw = w;
			c = 0;
			r.width = w;
			r.err = 1'b0;
			if (hi <= lo || d >= 1000) begin
				r.err = 1'b1;
			end else if (!pos_only) begin
				mid = (hi - lo) / 2 + lo;
				if (pw >= mid) begin
					num = pw - mid;
					den = hi - mid;
					neg = 1'b0;
				end else begin
					num = mid - pw;
					den = mid - lo;
					neg = 1'b1;
				end
				// empty lower half when the span is one
				if (den == 0) begin
					r.err = 1'b1;
				end else begin
					if (num > den)
						num = den;
					mag = strip_band(num, den, d);
					if (mag > 1000)
						mag = 1000;
					c = longint'(mag);
					if (neg)
						c = -c;
					if (rev)
						c = -c;
				end
			end else begin
				den = hi - lo;
				num = 0;
				if (rev) begin
					if (hi > pw)
						num = hi - pw;
				end else if (pw > lo) begin
					num = pw - lo;
				end
				mag = strip_band(num, den, d);
				if (mag > 1000)
					mag = 1000;
				c = longint'(mag);
			end
			r.cmd = c[W_CMD-1:0];
			return r;
		endfunction

		function void note_input(logic [W_PULSE-1:0] w);
			expected_cmds.push_back(calc_command(w));
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(logic signed [W_CMD-1:0] got_cmd, logic got_err);
			command_t want;
			if (expected_cmds.size() == 0) begin
				report($sformatf("unexpected command %0d error %0b", got_cmd, got_err));
				return;
			end
			want = expected_cmds.pop_front();
			if (got_cmd !== want.cmd || got_err !== want.err)
				report($sformatf("width %0d: command %0d error %0b, want %0d error %0b",
					want.width, got_cmd, got_err, want.cmd, want.err));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   hold_reqs;
	int   cur_lo;
	int   cur_hi;
	int   cycles;
	command_checker chk = new();

	pwpc_meas_if meas_ch();
	pwpc_cmd_if  cmd_ch();
	pwpc_cfg_if  cfg_ch();

	pulse_width_to_permille_channel uut (
		.clk(clk),
		.arst_n(arst_n),
		.meas(meas_ch),
		.cmd(cmd_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("pulse_width_to_permille_channel test failed");
				$finish;
			end
		end
	end

	// command sink: checks each transaction and throttles ready
	initial begin : sink_proc
		int burst, hold_left, hold_taken;
		burst = 0;
		hold_left = 0;
		hold_taken = 0;
		cmd_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && cmd_ch.valid && cmd_ch.ready)
				chk.check(cmd_ch.command_permille, cmd_ch.config_error);
			if (hold_left > 0) begin
				hold_left--;
				cmd_ch.ready <= 1'b0;
			end else if (hold_taken != hold_reqs) begin
				// long hold so the pipeline fills and stalls the input
				hold_taken = hold_reqs;
				hold_left = LONG_HOLD - 1;
				cmd_ch.ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				cmd_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 4) - 1;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_meas(input logic [W_PULSE-1:0] w);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			meas_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.pulse_width_us <= w;
		do @(posedge clk); while (!meas_ch.ready);
		chk.note_input(w);
	endtask

	// cfg valid stays high across back-to-back writes, caller lowers it
	task automatic write_reg(input logic [W_IDX-1:0] idx, input logic [W_DATA-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		chk.write_reg(idx, data);
	endtask

	task automatic set_regs(input int lo, input int hi, input logic [W_DATA-1:0] band_data,
			input logic [W_DATA-1:0] rev_data, input logic [W_DATA-1:0] pos_data);
		write_reg(REG_LOW_WIDTH, W_DATA'(lo));
		write_reg(REG_HIGH_WIDTH, W_DATA'(hi));
		write_reg(REG_DEAD_BAND, band_data);
		write_reg(REG_REVERSE, rev_data);
		write_reg(REG_POS_ONLY, pos_data);
		cfg_ch.valid <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
		@(posedge clk);
	endtask

	task automatic drain();
		meas_ch.valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (NUM_STAGES + 4) @(posedge clk);
	endtask

	task automatic random_config();
		int lo, hi, band;
		logic [W_DATA-1:0] band_data;
		case ($urandom_range(0, 9))
			0: begin
				lo = 0;
				hi = 65535;
			end
			1: begin
				lo = $urandom_range(0, 65535);
				hi = $urandom_range(0, lo);
			end
			2: begin
				lo = $urandom_range(0, 65534);
				hi = lo + 1;
			end
			3: begin
				lo = $urandom_range(0, 65532);
				hi = lo + int'($urandom_range(2, 3));
			end
			default: begin
				lo = $urandom_range(0, 60000);
				hi = lo + int'($urandom_range(1, 5000));
			end
		endcase
		case ($urandom_range(0, 7))
			0: band = 0;
			1: band = 999;
			2: band = $urandom_range(1000, 1023);
			3, 4: band = $urandom_range(0, 50);
			default: band = $urandom_range(0, 999);
		endcase
		// upper bits of the data word are junk the block must ignore
		band_data = {6'($urandom), 10'(band)};
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_POS_ONLY + W_IDX'($urandom_range(1, 3)), W_DATA'($urandom));
		set_regs(lo, hi, band_data, W_DATA'($urandom), W_DATA'($urandom));
	endtask

	function automatic logic [W_PULSE-1:0] pick_width(int lo, int hi);
		int span, a, b, v;
		span = (hi > lo) ? hi - lo : 4;
		if (span < 4)
			span = 4;
		case ($urandom_range(0, 9))
			0: return W_PULSE'($urandom);
			1: return $urandom_range(0, 1) ? '1 : '0;
			2: begin
				case ($urandom_range(0, 2))
					0: v = lo;
					1: v = hi;
					default: v = (hi - lo) / 2 + lo;
				endcase
				v = v + int'($urandom_range(0, 2)) - 1;
			end
			default: begin
				a = lo - span / 4;
				b = hi + span / 4;
				if (a > b) begin
					v = a;
					a = b;
					b = v;
				end
				v = a + int'($urandom_range(0, b - a));
			end
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return W_PULSE'(v);
	endfunction

	initial begin
		arst_n = 1'b0;
		idle_en = 1'b1;
		hold_reqs = 0;
		cur_lo = RST_LOW_WIDTH;
		cur_hi = RST_HIGH_WIDTH;
		meas_ch.valid = 1'b0;
		meas_ch.pulse_width_us = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_LOW_WIDTH;
		cfg_ch.wdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, around the midpoint and beyond full scale
		send_meas(16'd0);
		send_meas(16'd999);
		send_meas(16'd1000);
		send_meas(16'd1499);
		send_meas(16'd1500);
		send_meas(16'd1501);
		send_meas(16'd2000);
		send_meas(16'd2001);
		send_meas(16'hFFFF);
		drain();

		// widest limits, widest valid dead band, reversed
		set_regs(0, 65535, 16'd999, 16'd1, 16'd0);
		send_meas(16'd0);
		send_meas(16'd32767);
		send_meas(16'hFFFF);
		drain();

		// span of one leaves the lower half empty
		set_regs(500, 501, 16'd0, 16'd0, 16'd0);
		send_meas(16'd499);
		send_meas(16'd500);
		send_meas(16'd501);
		drain();

		// limits not ordered
		set_regs(2000, 2000, 16'd0, 16'd0, 16'd0);
		send_meas(16'd2000);
		drain();

		// dead band register above the valid range
		set_regs(1000, 2000, 16'd1023, 16'd0, 16'd0);
		send_meas(16'd1700);
		drain();

		// positive-only reversed, then plain over the full range
		set_regs(1000, 2000, 16'd100, 16'd1, 16'd1);
		send_meas(16'd900);
		send_meas(16'd1500);
		send_meas(16'd2100);
		drain();
		set_regs(0, 65535, 16'd0, 16'd0, 16'd1);
		send_meas(16'd0);
		send_meas(16'hFFFF);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_config();
			if (p == 0)
				hold_reqs++;
			if (p == RAND_PHASES - 1)
				idle_en = 1'b0;
			repeat (PHASE_ITEMS) send_meas(pick_width(cur_lo, cur_hi));
			drain();
		end

		repeat (2 * NUM_STAGES) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("pulse_width_to_permille_channel test passed");
		else
			$display("pulse_width_to_permille_channel test failed");
		$finish;
	end
endmodule
